// File: src/assert_macros.svh
// assertion helper macros for the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define LPDW_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define LPDW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lpdw_pkg.sv
// shared types and constants for the length-prefixed deframer with watchdog
// no dependencies
package lpdw_pkg;

   localparam int unsigned MAX_BODY      = 1024;
   localparam int unsigned LEN_W         = 11;
   localparam int unsigned MS_W          = 17;
   localparam int unsigned TIMEOUT_W     = 16;

   localparam logic [7:0]           TYPE_T        = 8'h54;
   localparam logic [MS_W-1:0]      MS_MAX        = {MS_W{1'b1}};
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   // input item kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_CONNECT = 2'd2;
   localparam logic [1:0] KIND_PEER    = 2'd3;

   // result event codes
   localparam logic [2:0] EV_BYTE      = 3'd0;
   localparam logic [2:0] EV_EMPTY     = 3'd1;
   localparam logic [2:0] EV_BADLEN    = 3'd2;
   localparam logic [2:0] EV_HEARTBEAT = 3'd3;
   localparam logic [2:0] EV_PEER      = 3'd4;

   // framing phase, one-hot
   typedef enum logic [5:0] {
      PH_LEN0    = 6'b000001,
      PH_LEN1    = 6'b000010,
      PH_LEN2    = 6'b000100,
      PH_LEN3    = 6'b001000,
      PH_TYPE    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] payload_byte;
      logic       last;
   } rsp_type;

endpackage

// File: src/length_prefixed_deframer_watchdog.sv
// Length-prefixed frame deframer with heartbeat watchdog.
// req channel: one item per transfer (link byte, millisecond tick, client
//   connect, peer close); req_ready is high whenever the input register is
//   empty or its item moves on in the same cycle.
// rsp channel: at most one event per item (T payload byte, empty T frame, or a
//   drop report for bad length, heartbeat timeout or peer close).
// csr channel: one write-only register, the heartbeat timeout in ticks
//   (0 disables the watchdog); csr_ready is always high. Write only while idle.
// Path: an accepted item is decoded in the input register and its event, if
//   any, is registered in the rsp register when the item advances.
// Throughput: one item per cycle unless rsp_ready stalls the result register;
//   the only loop is the framing state update between the two registers.
// Stall: while a result waits on rsp_ready, the input register holds one more
//   item and then req_ready drops; nothing is lost or repeated.
// Reset: link down, framing cleared, timeout 1000, both registers empty.
// A drop event means payload already passed out for the unfinished frame must
//   be discarded downstream.
// Depends on lpdw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module length_prefixed_deframer_watchdog
   import lpdw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TIMEOUT_W-1:0] csr_data
);

   // registers
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 in_valid_ff;
   req_type              in_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic                 link_up_ff, link_up_in;
   phase_type            phase_ff, phase_in;
   logic [LEN_W-1:0]     body_length_ff, body_length_in;
   logic                 too_long_ff, too_long_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic                 frame_is_t_ff, frame_is_t_in;
   logic [MS_W-1:0]      ms_ff, ms_in;

   logic                 advance;
   logic                 res_valid;
   rsp_type              res;
   logic                 drop;
   logic [LEN_W-1:0]     left_dec;
   logic [MS_W-1:0]      ms_inc;
   logic                 len_bad;

   // handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign left_dec = bytes_left_ff - LEN_W'(1);
   assign ms_inc   = (ms_ff == MS_MAX) ? ms_ff : ms_ff + MS_W'(1);
   assign len_bad  = too_long_ff || (in_ff.data_byte != 8'd0) ||
                     (body_length_ff == '0) ||
                     (body_length_ff > LEN_W'(MAX_BODY));

   // framing and watchdog update for the item in the input register
   always_comb begin
      link_up_in     = link_up_ff;
      phase_in       = phase_ff;
      body_length_in = body_length_ff;
      too_long_in    = too_long_ff;
      bytes_left_in  = bytes_left_ff;
      frame_is_t_in  = frame_is_t_ff;
      ms_in          = ms_ff;
      res_valid      = 1'b0;
      res            = '0;
      drop           = 1'b0;
      unique case (in_ff.kind)
         KIND_BYTE: begin
            if (link_up_ff) begin
               unique case (phase_ff)
                  PH_LEN0: begin
                     body_length_in = {3'b000, in_ff.data_byte};
                     too_long_in    = 1'b0;
                     phase_in       = PH_LEN1;
                  end
                  PH_LEN1: begin
                     body_length_in = {in_ff.data_byte[2:0], body_length_ff[7:0]};
                     too_long_in    = too_long_ff || (in_ff.data_byte[7:3] != 5'd0);
                     phase_in       = PH_LEN2;
                  end
                  PH_LEN2: begin
                     too_long_in = too_long_ff || (in_ff.data_byte != 8'd0);
                     phase_in    = PH_LEN3;
                  end
                  PH_LEN3: begin
                     if (len_bad) begin
                        drop          = 1'b1;
                        res.event_res = EV_BADLEN;
                     end else begin
                        bytes_left_in = body_length_ff;
                        phase_in      = PH_TYPE;
                     end
                  end
                  PH_TYPE: begin
                     frame_is_t_in = (in_ff.data_byte == TYPE_T);
                     bytes_left_in = left_dec;
                     if (left_dec == '0) begin
                        phase_in = PH_LEN0;
                        if (in_ff.data_byte == TYPE_T) begin
                           ms_in         = '0;
                           res_valid     = 1'b1;
                           res.event_res = EV_EMPTY;
                           res.last      = 1'b1;
                        end
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     bytes_left_in    = left_dec;
                     res.event_res    = EV_BYTE;
                     res.payload_byte = in_ff.data_byte;
                     res_valid        = frame_is_t_ff;
                     if (left_dec == '0) begin
                        phase_in = PH_LEN0;
                        res.last = 1'b1;
                        if (frame_is_t_ff) begin
                           ms_in = '0;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_LEN0;
                  end
               endcase
            end
         end
         KIND_TICK: begin
            if (link_up_ff) begin
               ms_in = ms_inc;
               if ((timeout_ff != '0) && (ms_inc > {1'b0, timeout_ff})) begin
                  drop          = 1'b1;
                  res.event_res = EV_HEARTBEAT;
               end
            end
         end
         KIND_CONNECT: begin
            if (!link_up_ff) begin
               link_up_in     = 1'b1;
               phase_in       = PH_LEN0;
               body_length_in = '0;
               too_long_in    = 1'b0;
               bytes_left_in  = '0;
               frame_is_t_in  = 1'b0;
               ms_in          = '0;
            end
         end
         KIND_PEER: begin
            if (link_up_ff) begin
               drop          = 1'b1;
               res.event_res = EV_PEER;
            end
         end
         default: begin
         end
      endcase
      // any drop reports an event, takes the link down and clears the framing state and heartbeat counter
      if (drop) begin
         res_valid      = 1'b1;
         res.last       = 1'b0;
         link_up_in     = 1'b0;
         phase_in       = PH_LEN0;
         body_length_in = '0;
         too_long_in    = 1'b0;
         bytes_left_in  = '0;
         frame_is_t_in  = 1'b0;
         ms_in          = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         link_up_ff     <= 1'b0;
         phase_ff       <= PH_LEN0;
         body_length_ff <= '0;
         too_long_ff    <= 1'b0;
         bytes_left_ff  <= '0;
         frame_is_t_ff  <= 1'b0;
         ms_ff          <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff   <= res_valid;
            link_up_ff     <= link_up_in;
            phase_ff       <= phase_in;
            body_length_ff <= body_length_in;
            too_long_ff    <= too_long_in;
            bytes_left_ff  <= bytes_left_in;
            frame_is_t_ff  <= frame_is_t_in;
            ms_ff          <= ms_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   // checks
   `LPDW_ASSERT_NEXT(a_drop_takes_link_down, advance && drop, !link_up_ff,
      "link still up after a drop event")
   `LPDW_ASSERT_SAME(a_down_is_clear, !link_up_ff,
      (phase_ff == PH_LEN0) && (ms_ff == '0) && (bytes_left_ff == '0) && !frame_is_t_ff,
      "framing state not cleared while link is down")
   `LPDW_ASSERT_NEXT(a_done_frame_restarts_watchdog, advance && res_valid && res.last,
      ms_ff == '0, "heartbeat counter not restarted by a completed frame")
   `LPDW_ASSERT_SAME(a_no_result_while_down, advance && !link_up_ff, !res_valid,
      "result produced while link is down")

endmodule
